// ----- rtl/rast_pkg.sv -----
package rast_pkg;

  // Element count of the store and address width of the tree memory
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned ADDR_W = 10;
  // Fenwick index runs 1..DEPTH and may step once past it
  localparam int unsigned FIDX_W = ADDR_W + 2;

  // Field widths
  localparam int unsigned ACT_W = 2;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned ADD_W = 32;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned CFG_W = 11;

  // Size after reset
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(1024);

  // Memory word: upper half weighted sums, lower half plain sums
  localparam int unsigned WORD_W = 2 * SUM_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 2'd0,
    ACT_SUM = 2'd1,
    ACT_CLR = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

endpackage

// ----- rtl/rast_ram.sv -----
module rast_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/range_add_range_sum_tree_unit.sv -----
// Channel | Direction | Handshake              | Payload
// in_     | input     | in_valid / in_stall    | action, first_index, last_index, add_value
// out_    | output    | out_valid / out_stall  | range_sum
// cfg_    | input     | cfg_valid / cfg_ready  | size_in_use
//
// The store is a pair of Fenwick trees in one 1024 x 128 memory, walked one node
// at a time: read, then add and write back on a range add, or add into the
// running sums on a range sum. Reset, a clear request and a size write each
// start a clearing pass over all 1024 words; in_stall is high during it, while
// a request is processed or its result waits, and while cfg_valid is high.
// A finished sum waits in the output register while out_stall is high.
module range_add_range_sum_tree_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rast_pkg::ACT_W-1:0]          in_action,
  input  logic [rast_pkg::IDX_W-1:0]          in_first_index,
  input  logic [rast_pkg::IDX_W-1:0]          in_last_index,
  input  logic signed [rast_pkg::ADD_W-1:0]   in_add_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rast_pkg::SUM_W-1:0]   out_range_sum,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rast_pkg::CFG_W-1:0]          cfg_size_in_use
);

  import rast_pkg::*;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_MUL, S_RD, S_DAT, S_QMUL, S_QFIN, S_OUT
  } state_t;

  state_t                    state_r;
  logic [ADDR_W-1:0]         clr_addr_r;
  logic [CFG_W-1:0]          size_r;
  logic                      out_valid_r;
  logic [SUM_W-1:0]          out_sum_r;
  action_t                   op_r;
  logic                      pass_r;
  logic [FIDX_W-1:0]         idx_r;
  logic signed [ADD_W-1:0]   val_r;
  logic [IDX_W-1:0]          x_r;
  logic [CFG_W-1:0]          b_r;
  logic [SUM_W-1:0]          d1_r, d2_r, s1_r, s2_r, acc_r, prod_r;

  action_t                   act;
  logic [CFG_W-1:0]          n_clamp;
  logic                      usable;
  logic [IDX_W-1:0]          y_clip;
  logic [CFG_W-1:0]          b_in;
  logic                      idx_ok;
  logic [FIDX_W-1:0]         lowbit;
  logic [CFG_W-1:0]          k_add;
  logic signed [43:0]        amul;
  logic [SUM_W-1:0]          amul_ext;
  logic [SUM_W-1:0]          val_ext;
  logic [CFG_W-1:0]          k_sum;
  logic [SUM_W-1:0]          qmul;
  logic [SUM_W-1:0]          part;
  logic                      ram_we, ram_re;
  logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
  logic [WORD_W-1:0]         ram_wdata, ram_rdata;

  // Decode the incoming request against the size in use
  assign act     = action_t'(in_action);
  assign n_clamp = (size_r > CFG_W'(DEPTH)) ? CFG_W'(DEPTH) : size_r;
  assign usable  = (n_clamp != '0) && (in_first_index <= in_last_index)
                   && ({1'b0, in_first_index} < n_clamp);
  assign y_clip  = ({1'b0, in_last_index} >= n_clamp) ? IDX_W'(n_clamp - CFG_W'(1))
                                                      : in_last_index;
  assign b_in    = {1'b0, y_clip} + CFG_W'(1);

  // Tree walk helpers
  assign idx_ok = (idx_r != '0) && (idx_r <= FIDX_W'(DEPTH));
  assign lowbit = idx_r & (~idx_r + FIDX_W'(1));

  // Deltas for the weighted tree: amount times boundary
  assign k_add    = pass_r ? b_r : {1'b0, x_r};
  assign amul     = val_r * $signed({1'b0, k_add});
  assign amul_ext = {{(SUM_W-44){amul[43]}}, amul};
  assign val_ext  = {{(SUM_W-ADD_W){val_r[ADD_W-1]}}, val_r};

  // Prefix scale: plain sum times prefix length
  assign k_sum = pass_r ? {1'b0, x_r} : b_r;
  assign qmul  = s1_r * k_sum;
  assign part  = prod_r - s2_r;

  // Memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = ADDR_W'(idx_r - FIDX_W'(1));
    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_RD: begin
        ram_re = idx_ok;
      end
      S_DAT: begin
        if (op_r == ACT_ADD) begin
          ram_we    = 1'b1;
          ram_waddr = ADDR_W'(idx_r - FIDX_W'(1));
          ram_wdata = {ram_rdata[WORD_W-1:SUM_W] + d2_r, ram_rdata[SUM_W-1:0] + d1_r};
        end
      end
      default: begin
      end
    endcase
  end

  rast_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once the beat is taken
      if (out_valid_r && !out_stall && (cfg_valid || state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        // size write restarts the clearing pass
        size_r     <= cfg_size_in_use;
        clr_addr_r <= '0;
        state_r    <= S_CLR;
      end else begin
        unique case (state_r)
          S_CLR: begin
            clr_addr_r <= clr_addr_r + ADDR_W'(1);
            if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              op_r   <= act;
              val_r  <= in_add_value;
              x_r    <= in_first_index;
              b_r    <= b_in;
              pass_r <= 1'b0;
              s1_r   <= '0;
              s2_r   <= '0;
              unique case (act)
                ACT_ADD: begin
                  if (usable) begin
                    idx_r   <= FIDX_W'(in_first_index) + FIDX_W'(1);
                    state_r <= S_MUL;
                  end
                end
                ACT_SUM: begin
                  if (usable) begin
                    idx_r   <= FIDX_W'(b_in);
                    state_r <= S_RD;
                  end else begin
                    acc_r   <= '0;
                    state_r <= S_OUT;
                  end
                end
                ACT_CLR: begin
                  clr_addr_r <= '0;
                  state_r    <= S_CLR;
                end
                default: begin
                end
              endcase
            end
          end
          S_MUL: begin
            d1_r    <= pass_r ? -val_ext : val_ext;
            d2_r    <= pass_r ? -amul_ext : amul_ext;
            state_r <= S_RD;
          end
          S_RD: begin
            if (idx_ok) begin
              state_r <= S_DAT;
            end else if (op_r == ACT_ADD) begin
              if (!pass_r) begin
                pass_r  <= 1'b1;
                idx_r   <= FIDX_W'(b_r) + FIDX_W'(1);
                state_r <= S_MUL;
              end else begin
                state_r <= S_IDLE;
              end
            end else begin
              state_r <= S_QMUL;
            end
          end
          S_DAT: begin
            if (op_r == ACT_ADD) begin
              idx_r <= idx_r + lowbit;
            end else begin
              s1_r  <= s1_r + ram_rdata[SUM_W-1:0];
              s2_r  <= s2_r + ram_rdata[WORD_W-1:SUM_W];
              idx_r <= idx_r - lowbit;
            end
            state_r <= S_RD;
          end
          S_QMUL: begin
            prod_r  <= qmul;
            state_r <= S_QFIN;
          end
          S_QFIN: begin
            if (!pass_r) begin
              acc_r   <= part;
              s1_r    <= '0;
              s2_r    <= '0;
              idx_r   <= FIDX_W'(x_r);
              pass_r  <= 1'b1;
              state_r <= S_RD;
            end else begin
              acc_r   <= acc_r - part;
              state_r <= S_OUT;
            end
          end
          S_OUT: begin
            // hold until the output register is free
            if (!out_valid_r || !out_stall) begin
              out_valid_r <= 1'b1;
              out_sum_r   <= acc_r;
              state_r     <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  assign in_stall      = (state_r != S_IDLE) || cfg_valid;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_range_sum = out_sum_r;

  a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLR || state_r == S_DAT))
    else $error("tree memory written outside clear or update");

  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result raised outside output step");

  a_upd_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DAT) |-> (idx_r != '0 && idx_r <= FIDX_W'(DEPTH)))
    else $error("tree index out of range during update");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r && $stable(out_sum_r))
    else $error("stalled result changed");

endmodule
